>>> rtl/integer_to_ascii_formatter_assert.svh
// Assertion macros for the integer to ASCII formatter.
// Needs nothing else; included by the top level inside its module body.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define ITAF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("itaf: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define ITAF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("itaf: next-cycle check failed");

`endif

>>> rtl/itaf_pkg.sv
// Shared types and constants for the integer to ASCII formatter.
// No dependencies; imported by the controller, the datapath and the top level.
package itaf_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MODE_W          = 2;
    localparam int CHAR_W          = 7;

    localparam logic [MODE_W-1:0] MODE_SDEC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UDEC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HEX  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_BIN  = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [3:0]        DIGIT_TEN  = 4'hA;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_ALIGN,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;       // capture value and mode
        logic dabble;     // one shift-add-3 step
        logic align;      // place digits at the top of the shifter
        logic skip_shift; // drop a leading zero digit
        logic out_sign;   // load '-' into the output register
        logic out_digit;  // load the top digit and advance
    } cmd_t;

    typedef struct packed {
        logic is_dec;
        logic neg;
        logic conv_last;
        logic digit_zero;
        logic cnt_one;
        logic out_free;
    } sts_t;

endpackage

>>> rtl/integer_to_ascii_formatter.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  s_value, s_mode
// m_        out        m_valid / m_ready  m_char_code, m_last
//
// One value at a time. Decimal modes run a shift-add-3 converter, one step
// per magnitude bit; hex and binary pass through that state unconverted.
// Then the digits are aligned, suppressed leading zeros are skipped, a minus
// sign is sent for a negative signed value, and the characters are sent.
// aresetn is synchronous and active low; it empties the output register.
// A stall on m_ready holds the sequencer; s_ready is high only between values.
module integer_to_ascii_formatter #(
    parameter int VALUE_WIDTH = itaf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [VALUE_WIDTH-1:0]        s_value,
    input  logic [itaf_pkg::MODE_W-1:0]   s_mode,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [itaf_pkg::CHAR_W-1:0]   m_char_code,
    output logic                          m_last
);
    import itaf_pkg::*;
    `include "integer_to_ascii_formatter_assert.svh"

    cmd_t cmd;
    sts_t sts;

    itaf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    itaf_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_value     (s_value),
        .s_mode      (s_mode),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last      (m_last)
    );

    // the block is busy right after taking a value
    `ITAF_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a minus sign never ends a value
    `ITAF_ASSERT_NOW(a_minus_not_last, aclk, aresetn, m_valid && (m_char_code == CHAR_MINUS), !m_last)
    // the final digit shows up flagged as last
    `ITAF_ASSERT_NEXT(a_final_digit_last, aclk, aresetn, cmd.out_digit && sts.cnt_one, m_valid && m_last)

endmodule

>>> rtl/itaf_ctrl.sv
// Sequencer for the integer to ASCII formatter.
// Depends on itaf_pkg; drives the datapath only through cmd_t and reads sts_t.
module itaf_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  itaf_pkg::sts_t  sts,
    output itaf_pkg::cmd_t  cmd
);
    import itaf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                // hex and binary need no conversion
                if (!sts.is_dec) begin
                    state_next = ST_ALIGN;
                end else begin
                    cmd.dabble = 1'b1;
                    if (sts.conv_last) begin
                        state_next = ST_ALIGN;
                    end
                end
            end
            ST_ALIGN: begin
                cmd.align  = 1'b1;
                state_next = ST_SKIP;
            end
            ST_SKIP: begin
                if (sts.digit_zero && !sts.cnt_one) begin
                    cmd.skip_shift = 1'b1;
                end else if (sts.neg) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (sts.out_free) begin
                    cmd.out_sign = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_digit = 1'b1;
                    if (sts.cnt_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/itaf_datapath.sv
// Datapath of the integer to ASCII formatter: magnitude, BCD converter,
// digit shifter and output register. Depends on itaf_pkg.
module itaf_datapath #(
    parameter int VALUE_WIDTH = itaf_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [VALUE_WIDTH-1:0]        s_value,
    input  logic [itaf_pkg::MODE_W-1:0]   s_mode,
    input  itaf_pkg::cmd_t                cmd,
    output itaf_pkg::sts_t                sts,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [itaf_pkg::CHAR_W-1:0]   m_char_code,
    output logic                          m_last
);
    import itaf_pkg::*;

    // decimal digits needed for 2^VALUE_WIDTH - 1 (log10(2) ~ 0.30103)
    localparam int NDIG   = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int NHEX   = (VALUE_WIDTH + 3) / 4;
    localparam int BCD_W  = NDIG * 4;
    localparam int HEX_W  = NHEX * 4;
    localparam int SH_A   = (BCD_W > HEX_W) ? BCD_W : HEX_W;
    localparam int SH_W   = (SH_A > VALUE_WIDTH) ? SH_A : VALUE_WIDTH;
    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int CONV_W = $clog2(VALUE_WIDTH);

    logic [MODE_W-1:0]      mode_reg;
    logic                   neg_reg;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic [CONV_W-1:0]      conv_cnt_reg;
    logic [SH_W-1:0]        sh_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   m_valid_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;

    logic                   load_neg;
    logic [VALUE_WIDTH-1:0] load_mag;
    logic [BCD_W-1:0]       bcd_adj;
    logic [BCD_W-1:0]       bcd_next;
    logic [3:0]             digit;
    logic [CHAR_W-1:0]      digit_char;
    logic                   is_bin;
    logic                   advance;
    logic [SH_W-1:0]        sh_shifted;

    assign load_neg = (s_mode == MODE_SDEC) && s_value[VALUE_WIDTH-1];
    assign load_mag = load_neg ? (~s_value + VALUE_WIDTH'(1)) : s_value;

    // add 3 to every BCD digit of 5 or more, then shift in the next magnitude bit
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            bcd_adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ?
                                (bcd_reg[i*4 +: 4] + 4'd3) : bcd_reg[i*4 +: 4];
        end
    end
    assign bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};

    assign is_bin     = (mode_reg == MODE_BIN);
    assign digit      = is_bin ? {3'b000, sh_reg[SH_W-1]} : sh_reg[SH_W-1 -: 4];
    assign digit_char = (digit < DIGIT_TEN) ? (CHAR_ZERO + CHAR_W'(digit))
                                            : (CHAR_A + CHAR_W'(digit - DIGIT_TEN));
    assign sh_shifted = is_bin ? (sh_reg << 1) : (sh_reg << 4);
    assign advance    = cmd.skip_shift || cmd.out_digit;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg     <= s_mode;
            neg_reg      <= load_neg;
            mag_reg      <= load_mag;
            bcd_reg      <= '0;
            conv_cnt_reg <= '0;
        end else if (cmd.dabble) begin
            mag_reg      <= mag_reg << 1;
            bcd_reg      <= bcd_next;
            conv_cnt_reg <= conv_cnt_reg + CONV_W'(1);
        end
    end

    // left-align the digits so the most significant one sits at the top
    always_ff @(posedge aclk) begin
        if (cmd.align) begin
            unique case (mode_reg)
                MODE_SDEC, MODE_UDEC: begin
                    sh_reg  <= SH_W'(bcd_reg) << (SH_W - BCD_W);
                    cnt_reg <= CNT_W'(NDIG);
                end
                MODE_HEX: begin
                    sh_reg  <= SH_W'(mag_reg) << (SH_W - HEX_W);
                    cnt_reg <= CNT_W'(NHEX);
                end
                MODE_BIN: begin
                    sh_reg  <= SH_W'(mag_reg) << (SH_W - VALUE_WIDTH);
                    cnt_reg <= CNT_W'(VALUE_WIDTH);
                end
                default: begin
                    sh_reg  <= sh_reg;
                    cnt_reg <= cnt_reg;
                end
            endcase
        end else if (advance) begin
            sh_reg  <= sh_shifted;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // output register: load when empty or when the current transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_sign || cmd.out_digit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_sign) begin
            char_reg <= CHAR_MINUS;
            last_reg <= 1'b0;
        end else if (cmd.out_digit) begin
            char_reg <= digit_char;
            last_reg <= (cnt_reg == CNT_W'(1));
        end
    end

    assign sts.is_dec     = (mode_reg == MODE_SDEC) || (mode_reg == MODE_UDEC);
    assign sts.neg        = neg_reg;
    assign sts.conv_last  = (conv_cnt_reg == CONV_W'(VALUE_WIDTH - 1));
    assign sts.digit_zero = (digit == 4'd0);
    assign sts.cnt_one    = (cnt_reg == CNT_W'(1));
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_char_code = char_reg;
    assign m_last      = last_reg;

endmodule

>>> verif/integer_to_ascii_formatter_tb.sv
// Self-checking testbench for integer_to_ascii_formatter: directed and random values in all
// four formats, with the expected text predicted in the bench. Depends on itaf_pkg and the RTL.
`timescale 1ns / 100ps

module integer_to_ascii_formatter_tb;
    import itaf_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int RANDOM_VALUES = 110;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    localparam logic [MODE_W-1:0] ALL_MODES [4] = '{MODE_SDEC, MODE_UDEC, MODE_HEX, MODE_BIN};
    localparam logic [31:0] POW10 [9] = '{32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000,
        32'd1000000, 32'd10000000, 32'd100000000, 32'd1000000000};

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [31:0]          s_value;
    logic [MODE_W-1:0]    s_mode;
    logic                 m_valid;
    logic                 m_ready;
    logic [CHAR_W-1:0]    m_char_code;
    logic                 m_last;

    text_char_t text_q[$];
    int         errors;
    int         cycle_cnt;
    int         chars_checked;
    int         values_sent;
    int         mode_count [4];
    bit         src_idle;
    bit         sink_stall;
    int         stall_left;

    integer_to_ascii_formatter u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .s_mode      (s_mode),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_code (m_char_code),
        .m_last      (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Append the characters the formatter should produce for one value.
    function automatic void format_value(input logic [31:0] value, input logic [MODE_W-1:0] mode);
        logic [31:0]       mag;
        logic [CHAR_W-1:0] rev [0:31];
        logic [3:0]        nib;
        int                nd;
        mag = value;
        nd  = 0;
        if (mode == MODE_SDEC && value[31]) begin
            mag = -value;
            text_q.push_back('{code: CHAR_MINUS, last: 1'b0});
        end
        if (mag == 0) begin
            rev[0] = CHAR_ZERO;
            nd     = 1;
        end
        while (mag != 0) begin
            case (mode)
                MODE_HEX: begin
                    nib     = mag[3:0];
                    rev[nd] = (nib < DIGIT_TEN) ? CHAR_ZERO + nib : CHAR_A + (nib - DIGIT_TEN);
                    mag     = mag >> 4;
                end
                MODE_BIN: begin
                    rev[nd] = CHAR_ZERO + mag[0];
                    mag     = mag >> 1;
                end
                default: begin
                    rev[nd] = CHAR_ZERO + CHAR_W'(mag % 10);
                    mag     = mag / 10;
                end
            endcase
            nd++;
        end
        for (int i = nd - 1; i >= 0; i--)
            text_q.push_back('{code: rev[i], last: (i == 0)});
    endfunction

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20);
            1: return -$urandom_range(1, 20);
            2: return POW10[$urandom_range(0, 8)] - $urandom_range(0, 1);
            3: return $urandom >> $urandom_range(0, 31);
            4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_value(input logic [31:0] value, input logic [MODE_W-1:0] mode);
        int gap;
        gap = src_idle ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            s_value <= $urandom;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        s_mode  <= mode;
        do @(posedge aclk); while (!s_ready);
        format_value(value, mode);
        values_sent++;
        mode_count[mode]++;
    endtask

    // Drop valid, then hold until all predicted text has come out.
    task automatic wait_text_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (text_q.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        src_idle   = 1'b1;
        sink_stall = 1'b1;
        foreach (ALL_MODES[i]) begin
            send_value(32'h0000_0000, ALL_MODES[i]);
            send_value(32'hFFFF_FFFF, ALL_MODES[i]);
            send_value(32'h8000_0000, ALL_MODES[i]);
            send_value(32'h7FFF_FFFF, ALL_MODES[i]);
        end
        send_value(32'd1, MODE_SDEC);
        send_value(32'd9, MODE_UDEC);
        send_value(32'd10, MODE_SDEC);
        send_value(32'hDEAD_BEEF, MODE_HEX);
        send_value(32'h00AB_CDEF, MODE_HEX);
        send_value(32'd4294967286, MODE_SDEC);
    endtask

    task automatic test_back_to_back();
        src_idle   = 1'b0;
        sink_stall = 1'b0;
        repeat (20) send_value(random_value(), ALL_MODES[$urandom_range(0, 3)]);
    endtask

    task automatic test_drain_pause();
        src_idle   = 1'b1;
        sink_stall = 1'b1;
        repeat (4) send_value(random_value(), ALL_MODES[$urandom_range(0, 3)]);
        wait_text_drained();
        repeat (4) send_value(random_value(), ALL_MODES[$urandom_range(0, 3)]);
    endtask

    task automatic test_random();
        src_idle   = 1'b1;
        sink_stall = 1'b1;
        repeat (RANDOM_VALUES) send_value(random_value(), ALL_MODES[$urandom_range(0, 3)]);
    endtask

    // Result sink backpressure.
    always @(negedge aclk) begin : sink_ready
        int g;
        if (!sink_stall) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            g = pick_gap();
            m_ready <= (g == 0);
            if (g > 0) stall_left = g - 1;
        end
    end

    always @(posedge aclk) begin : text_check
        text_char_t want;
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("integer_to_ascii_formatter_tb failed");
            $finish;
        end else if (aresetn && m_valid && m_ready) begin
            chars_checked++;
            if (text_q.size() == 0) begin
                $error("unexpected transfer: char_code %h last %b", m_char_code, m_last);
                errors++;
            end else begin
                want = text_q.pop_front();
                if (m_char_code !== want.code) begin
                    $error("char_code: expected %h, got %h", want.code, m_char_code);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %b, got %b", want.last, m_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_value    = '0;
        s_mode     = MODE_SDEC;
        m_ready    = 1'b0;
        errors     = 0;
        cycle_cnt  = 0;
        stall_left = 0;
        src_idle   = 1'b1;
        sink_stall = 1'b1;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_back_to_back();
        test_drain_pause();
        test_random();

        wait_text_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (text_q.size() != 0) begin
            $error("%0d predicted characters never arrived", text_q.size());
            errors++;
        end
        $display("Formatted %0d values (signed %0d, unsigned %0d, hex %0d, binary %0d),",
                 values_sent, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
        $display("checked %0d characters under random stalls on both channels.", chars_checked);
        if (errors == 0)
            $display("integer_to_ascii_formatter_tb passed");
        else
            $display("integer_to_ascii_formatter_tb failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/itaf_pkg.sv
rtl/itaf_ctrl.sv
rtl/itaf_datapath.sv
rtl/integer_to_ascii_formatter.sv
verif/integer_to_ascii_formatter_tb.sv
